// ===== rtl/bse_pkg.sv =====
// Shared types, register indexes and the charge curve for the battery charge estimator.
`default_nettype none
package bse_pkg;

  localparam int MAX_SAMPLES_DEF = 64;
  localparam int TABLE_POINTS    = 12;

  localparam int SAMPLE_W = 12;
  localparam int CNT_W    = 7;
  localparam int RATIO_W  = 13;
  localparam int MV_W     = 16;
  localparam int PCT_W    = 10;
  localparam int PS_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Interpolation widths: segment span and voltage offset below 512 mV,
  // charge step per segment below 128 tenths.
  localparam int DEN_W = 9;
  localparam int DP_W  = 7;
  localparam int NUM_W = DEN_W + DP_W;
  localparam int SEG_W = $clog2(TABLE_POINTS);

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENT_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL     = 3'd4;

  localparam logic [CNT_W-1:0]   RST_SAMPLE_COUNT = 7'd16;
  localparam logic [RATIO_W-1:0] RST_DIVIDER      = 13'd512;
  localparam logic [MV_W-1:0]    RST_PRESENT_MIN  = 16'd2500;
  localparam logic [PCT_W-1:0]   RST_LOW          = 10'd200;
  localparam logic [PCT_W-1:0]   RST_CRITICAL     = 10'd50;

  localparam logic [PCT_W-1:0] FULL_TENTHS = 10'd1000;

  localparam logic [PS_W-1:0] PS_NORMAL   = 2'd0;
  localparam logic [PS_W-1:0] PS_LOW      = 2'd1;
  localparam logic [PS_W-1:0] PS_CRITICAL = 2'd2;

  // Discharge curve, descending in both voltage and charge.
  localparam logic [MV_W-1:0] CURVE_MV [TABLE_POINTS] = '{
    16'd4200, 16'd4100, 16'd4000, 16'd3920, 16'd3860, 16'd3820,
    16'd3790, 16'd3770, 16'd3730, 16'd3690, 16'd3610, 16'd3300
  };
  localparam logic [PCT_W-1:0] CURVE_PCT [TABLE_POINTS] = '{
    10'd1000, 10'd900, 10'd800, 10'd700, 10'd600, 10'd500,
    10'd400,  10'd300, 10'd200, 10'd100, 10'd50,  10'd0
  };

  typedef struct packed {
    logic accept;
    logic avg_start;
    logic pct_start;
    logic load_cell;
    logic load_seg;
    logic load_pct;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic due;
    logic div_done;
    logic skip_div;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/bse_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module bse_div #(
  parameter int DIV_W = 19
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [DIV_W-1:0]          dividend,
  input  wire logic [bse_pkg::DEN_W-1:0] divisor,
  output logic      [DIV_W-1:0]          quotient,
  output logic                           done
);
  import bse_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   shifted;
  logic             fits;
  logic [DEN_W-1:0] rem_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[DIV_W-1]};
    fits    = shifted >= {1'b0, den_r};
    rem_nxt = fits ? DEN_W'(shifted - {1'b0, den_r}) : shifted[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule
`default_nettype wire

// ===== rtl/bse_datapath.sv =====
// Datapath: configuration registers, sample accumulator, scaling, curve lookup and result register.
`default_nettype none
module bse_datapath #(
  parameter int MAX_SAMPLES = bse_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire bse_pkg::cmd_t                  cmd,
  output bse_pkg::status_t                    status,
  input  wire logic [bse_pkg::SAMPLE_W-1:0]   in_sample_mv,
  input  wire logic                           cfg_we,
  input  wire logic [bse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bse_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [bse_pkg::MV_W-1:0]       out_cell_mv,
  output logic      [bse_pkg::PCT_W-1:0]      out_charge_tenths,
  output logic      [bse_pkg::PS_W-1:0]       out_power_state,
  output logic                                out_battery_present
);
  import bse_pkg::*;

  localparam int SUM_W  = SAMPLE_W + $clog2(MAX_SAMPLES + 1);
  localparam int DIV_W  = (SUM_W > NUM_W) ? SUM_W : NUM_W;
  localparam int PROD_W = DIV_W + RATIO_W;

  // Configuration registers.
  logic [CNT_W-1:0]   count_cfg_r;
  logic [RATIO_W-1:0] ratio_r;
  logic [MV_W-1:0]    present_min_r;
  logic [PCT_W-1:0]   low_r;
  logic [PCT_W-1:0]   crit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_cfg_r   <= RST_SAMPLE_COUNT;
      ratio_r       <= RST_DIVIDER;
      present_min_r <= RST_PRESENT_MIN;
      low_r         <= RST_LOW;
      crit_r        <= RST_CRITICAL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_COUNT: count_cfg_r   <= cfg_data[CNT_W-1:0];
        REG_DIVIDER:      ratio_r       <= cfg_data[RATIO_W-1:0];
        REG_PRESENT_MIN:  present_min_r <= cfg_data[MV_W-1:0];
        REG_LOW:          low_r         <= cfg_data[PCT_W-1:0];
        REG_CRITICAL:     crit_r        <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sample count: zero acts as one, large counts clamp.
  logic [CNT_W-1:0] n_eff;
  always_comb begin
    if (count_cfg_r == '0)
      n_eff = CNT_W'(1);
    else if (32'(count_cfg_r) > MAX_SAMPLES)
      n_eff = CNT_W'(MAX_SAMPLES);
    else
      n_eff = count_cfg_r;
  end

  // Accumulator.
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] taken_r;
  logic [SUM_W-1:0] sum_in;
  logic             due;

  assign sum_in = sum_r + SUM_W'(in_sample_mv);
  assign due    = ({1'b0, taken_r} + 1'b1) >= {1'b0, n_eff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      taken_r <= '0;
    end else if (cmd.accept) begin
      if (due) begin
        sum_r   <= '0;
        taken_r <= '0;
      end else begin
        sum_r   <= sum_in;
        taken_r <= taken_r + 1'b1;
      end
    end
  end

  // Segment registers and interpolation terms.
  logic [MV_W-1:0]  cell_r;
  logic [SEG_W-1:0] seg_r;
  logic             present_r;
  logic             skip_r;
  logic [PCT_W-1:0] pct_r;

  logic [DEN_W-1:0] span;
  logic [DEN_W-1:0] dv;
  logic [DP_W-1:0]  dp;
  logic [NUM_W-1:0] num;

  always_comb begin
    span = DEN_W'(CURVE_MV[seg_r - 1'b1] - CURVE_MV[seg_r]);
    dv   = DEN_W'(cell_r - CURVE_MV[seg_r]);
    dp   = DP_W'(CURVE_PCT[seg_r - 1'b1] - CURVE_PCT[seg_r]);
    num  = NUM_W'(dv) * NUM_W'(dp);
  end

  // Shared divider: average first, interpolation second.
  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DEN_W-1:0] div_divisor;
  logic [DIV_W-1:0] quo;
  logic             div_done;

  always_comb begin
    div_start    = cmd.avg_start | cmd.pct_start;
    div_dividend = cmd.avg_start ? DIV_W'(sum_in) : DIV_W'(num);
    div_divisor  = cmd.avg_start ? DEN_W'(n_eff) : span;
  end

  bse_div #(
    .DIV_W(DIV_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .quotient(quo),
    .done    (div_done)
  );

  // Scale the average by the divider ratio and saturate.
  logic [PROD_W-1:0] prod;
  logic [PROD_W-9:0] scaled;
  logic [MV_W-1:0]   cell_nxt;

  always_comb begin
    prod     = PROD_W'(quo) * PROD_W'(ratio_r);
    scaled   = prod[PROD_W-1:8];
    cell_nxt = (scaled > (PROD_W-8)'(16'hFFFF)) ? 16'hFFFF : scaled[MV_W-1:0];
  end

  // Locate the curve segment: first point at or below the cell voltage.
  logic [SEG_W-1:0] seg;
  logic             above_top;
  logic             below_bot;
  logic             present;

  always_comb begin
    seg = '0;
    for (int i = TABLE_POINTS - 1; i >= 1; i--) begin
      if (cell_r >= CURVE_MV[i])
        seg = SEG_W'(i);
    end
    above_top = cell_r >= CURVE_MV[0];
    below_bot = cell_r <= CURVE_MV[TABLE_POINTS-1];
    present   = cell_r >= present_min_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_cell)
      cell_r <= cell_nxt;
    if (cmd.load_seg) begin
      seg_r     <= seg;
      present_r <= present;
      skip_r    <= !present || above_top || below_bot;
    end
    if (cmd.load_seg) begin
      if (!present)
        pct_r <= FULL_TENTHS;
      else if (above_top)
        pct_r <= CURVE_PCT[0];
      else
        pct_r <= CURVE_PCT[TABLE_POINTS-1];
    end else if (cmd.load_pct) begin
      pct_r <= CURVE_PCT[seg_r] + PCT_W'(quo);
    end
  end

  // Classification and result register.
  logic [PS_W-1:0] ps;
  always_comb begin
    if (!present_r)
      ps = PS_NORMAL;
    else if (pct_r <= crit_r)
      ps = PS_CRITICAL;
    else if (pct_r <= low_r)
      ps = PS_LOW;
    else
      ps = PS_NORMAL;
  end

  logic            out_valid_r;
  logic [MV_W-1:0] out_cell_r;
  logic [PCT_W-1:0] out_pct_r;
  logic [PS_W-1:0] out_ps_r;
  logic            out_present_r;
  logic            out_free;

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (cmd.load_out)
      out_valid_r <= 1'b1;
    else if (!out_stall)
      out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_cell_r    <= cell_r;
      out_pct_r     <= pct_r;
      out_ps_r      <= ps;
      out_present_r <= present_r;
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign status   = '{due: due, div_done: div_done, skip_div: skip_r, out_free: out_free};

  assign out_valid           = out_valid_r;
  assign out_cell_mv         = out_cell_r;
  assign out_charge_tenths   = out_pct_r;
  assign out_power_state     = out_ps_r;
  assign out_battery_present = out_present_r;

endmodule
`default_nettype wire

// ===== rtl/bse_ctrl.sv =====
// Controller that sequences accumulation, averaging, lookup and result hand-off.
`default_nettype none
module bse_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire bse_pkg::status_t status,
  output bse_pkg::cmd_t         cmd
);
  import bse_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AVG,
    S_SEG,
    S_INTERP,
    S_PCT,
    S_CLASS
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.due) begin
            cmd.avg_start = 1'b1;
            state_nxt     = S_AVG;
          end
        end
      end
      S_AVG: begin
        if (status.div_done) begin
          cmd.load_cell = 1'b1;
          state_nxt     = S_SEG;
        end
      end
      S_SEG: begin
        cmd.load_seg = 1'b1;
        state_nxt    = S_INTERP;
      end
      S_INTERP: begin
        if (status.skip_div) begin
          state_nxt = S_CLASS;
        end else begin
          cmd.pct_start = 1'b1;
          state_nxt     = S_PCT;
        end
      end
      S_PCT: begin
        if (status.div_done) begin
          cmd.load_pct = 1'b1;
          state_nxt    = S_CLASS;
        end
      end
      S_CLASS: begin
        // Wait here while the previous result still sits in the output register.
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      state_r <= S_IDLE;
    else
      state_r <= state_nxt;
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/battery_soc_estimator.sv =====
// Top level of the battery state-of-charge estimator.
//
// Input channel: one item per accepted in_valid/in_stall handshake carries a
// calibrated ADC reading in millivolts. Items that do not close a batch are
// taken one per cycle. The item that completes a batch of sample_count
// readings starts an estimate, and in_stall stays high while it runs.
// An estimate uses the shared restoring divider (19 bits wide at the default
// MAX_SAMPLES of 64): one divider pass forms the average, a second forms the
// interpolated charge. Clamped and no-battery cases skip the second pass.
// Output channel: one item per estimate, held in an output register until
// accepted; new samples are still taken while it waits. If out_stall keeps the
// register full when the next estimate finishes, the block holds that estimate
// and keeps in_stall high until the register frees.
// Configuration: cfg_ready is always high; write only while the block is idle.
// Reset (rst_n low, synchronous) clears the sum, sample count and output valid,
// and loads the register defaults 16, 512, 2500, 200 and 50.
`default_nettype none
module battery_soc_estimator #(
  parameter int MAX_SAMPLES = bse_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [bse_pkg::SAMPLE_W-1:0]   in_sample_mv,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [bse_pkg::MV_W-1:0]       out_cell_mv,
  output logic      [bse_pkg::PCT_W-1:0]      out_charge_tenths,
  output logic      [bse_pkg::PS_W-1:0]       out_power_state,
  output logic                                out_battery_present,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bse_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bse_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  bse_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  bse_datapath #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_sample_mv       (in_sample_mv),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_cell_mv        (out_cell_mv),
    .out_charge_tenths  (out_charge_tenths),
    .out_power_state    (out_power_state),
    .out_battery_present(out_battery_present)
  );

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the battery state-of-charge estimator.
module tb;
  import bse_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 800_000;
  localparam int RANDOM_ITEMS  = 1650;
  localparam int MAX_GAP       = 8;
  localparam int LONG_HOLD     = 400;
  localparam int MAX_REPORTS   = 10;
  localparam int KNEES         = 12;

  typedef struct packed {
    logic [MV_W-1:0]  cell_mv;
    logic [PCT_W-1:0] pct;
    logic [PS_W-1:0]  state;
    logic             present;
  } estimate_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   in_sample_mv = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [MV_W-1:0]       out_cell_mv;
  logic [PCT_W-1:0]      out_charge_tenths;
  logic [PS_W-1:0]       out_power_state;
  logic                  out_battery_present;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  battery_soc_estimator dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample_mv        (in_sample_mv),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cell_mv         (out_cell_mv),
    .out_charge_tenths   (out_charge_tenths),
    .out_power_state     (out_power_state),
    .out_battery_present (out_battery_present),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Discharge curve, highest voltage first.
  int knee_mv [KNEES] = '{4200, 4100, 4000, 3920, 3860, 3820,
                          3790, 3770, 3730, 3690, 3610, 3300};
  int knee_tenths [KNEES] = '{1000, 900, 800, 700, 600, 500,
                              400, 300, 200, 100, 50, 0};

  // Predicted register contents and accumulator.
  logic [CNT_W-1:0]   set_count      = 7'd16;
  logic [RATIO_W-1:0] set_ratio      = 13'd512;
  logic [MV_W-1:0]    set_present_mv = 16'd2500;
  logic [PCT_W-1:0]   set_low        = 10'd200;
  logic [PCT_W-1:0]   set_crit       = 10'd50;
  logic [17:0]        sum_mv         = '0;
  logic [CNT_W-1:0]   taken          = '0;

  estimate_t  estimate_q [$];
  reg_write_t reg_writes [$];
  int         fail_count = 0;
  int         cycle_count = 0;
  int         burst_left = 0;
  bit         gaps_on = 1'b1;
  int         batch_level = 0;
  bit         hold_request = 1'b0;
  int         hold_left = 0;
  int         mode_left = 0;
  int         stall_pct = 0;
  estimate_t  got;
  estimate_t  want;

  function automatic logic [PCT_W-1:0] charge_from_cell(input logic [MV_W-1:0] mv);
    int v;
    v = mv;
    if (v >= knee_mv[0]) return PCT_W'(knee_tenths[0]);
    if (v <= knee_mv[KNEES-1]) return PCT_W'(knee_tenths[KNEES-1]);
    for (int i = 1; i < KNEES; i++) begin
      if (v >= knee_mv[i]) begin
        return PCT_W'(knee_tenths[i] + ((v - knee_mv[i]) *
                      (knee_tenths[i-1] - knee_tenths[i])) / (knee_mv[i-1] - knee_mv[i]));
      end
    end
    return PCT_W'(knee_tenths[KNEES-1]);
  endfunction

  // Folds one accepted sample into the running sum and queues an estimate
  // whenever the batch is complete.
  function automatic void absorb_sample(input logic [SAMPLE_W-1:0] mv);
    int          n;
    logic [17:0] avg;
    logic [31:0] scaled;
    estimate_t   e;
    n = set_count;
    if (n == 0) n = 1;
    else if (n > MAX_SAMPLES_DEF) n = MAX_SAMPLES_DEF;
    sum_mv = sum_mv + mv;
    taken = taken + 1'b1;
    if (taken < n) return;
    avg = sum_mv / n;
    sum_mv = '0;
    taken = '0;
    scaled = (32'(avg) * 32'(set_ratio)) >> 8;
    e.cell_mv = (scaled > 32'd65535) ? 16'hFFFF : scaled[MV_W-1:0];
    if (e.cell_mv < set_present_mv) begin
      e.present = 1'b0;
      e.pct = FULL_TENTHS;
      e.state = PS_NORMAL;
    end else begin
      e.present = 1'b1;
      e.pct = charge_from_cell(e.cell_mv);
      if (e.pct <= set_crit) e.state = PS_CRITICAL;
      else if (e.pct <= set_low) e.state = PS_LOW;
      else e.state = PS_NORMAL;
    end
    estimate_q.push_back(e);
  endfunction

  task automatic stage_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    reg_write_t w;
    w.idx = idx;
    w.data = data;
    reg_writes.push_back(w);
  endtask

  // Writes every staged register back to back, then drops cfg_valid.
  task automatic apply_regs();
    reg_write_t w;
    while (reg_writes.size() > 0) begin
      w = reg_writes.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.idx;
      cfg_data <= w.data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (w.idx)
        REG_SAMPLE_COUNT: set_count = w.data[CNT_W-1:0];
        REG_DIVIDER:      set_ratio = w.data[RATIO_W-1:0];
        REG_PRESENT_MIN:  set_present_mv = w.data[MV_W-1:0];
        REG_LOW:          set_low = w.data[PCT_W-1:0];
        REG_CRITICAL:     set_crit = w.data[PCT_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] mv);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_sample_mv <= mv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_sample(mv);
  endtask

  // Waits until every estimate has come out, then lets the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (estimate_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Each batch aims at one cell voltage, mostly on the curve, with a little noise.
  function automatic logic [SAMPLE_W-1:0] next_sample();
    int s;
    int ratio;
    if (taken == 0) begin
      case ($urandom_range(0, 9))
        6:       batch_level = int'(set_present_mv) + $urandom_range(0, 40) - 20;
        7:       batch_level = $urandom_range(0, 65535);
        8:       batch_level = -1;
        9:       batch_level = -2;
        default: batch_level = $urandom_range(3250, 4250);
      endcase
    end
    if ($urandom_range(0, 9) == 0) return SAMPLE_W'($urandom_range(0, 4095));
    if (batch_level == -1) return '0;
    if (batch_level == -2) return '1;
    ratio = (set_ratio == 0) ? 1 : set_ratio;
    s = batch_level * 256 / ratio + $urandom_range(0, 16) - 8;
    if (s < 0) s = 0;
    if (s > 4095) s = 4095;
    return SAMPLE_W'(s);
  endfunction

  // Receiver: random stall density that changes every so often, or a long
  // hold-off when a test asks for one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_request || hold_left > 0) begin
      if (hold_request) begin
        hold_left = LONG_HOLD;
        hold_request = 1'b0;
      end
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(16, 256);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      mode_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got.cell_mv = out_cell_mv;
      got.pct = out_charge_tenths;
      got.state = out_power_state;
      got.present = out_battery_present;
      if (estimate_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected estimate: cell %0d charge %0d state %0d present %0d",
                   got.cell_mv, got.pct, got.state, got.present);
      end else begin
        want = estimate_q.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display({"estimate mismatch: expected cell %0d charge %0d state %0d",
                      " present %0d, got cell %0d charge %0d state %0d present %0d"},
                     want.cell_mv, want.pct, want.state, want.present,
                     got.cell_mv, got.pct, got.state, got.present);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Power-on settings, half full-scale and half zero readings.
  task automatic test_reset_defaults();
    for (int i = 0; i < 16; i++) send_sample((i % 2 == 0) ? 12'hFFF : 12'h000);
    drain();
  endtask

  // A partial batch stays in the sum when the count drops below what was taken.
  task automatic test_count_lowered();
    stage_reg(REG_SAMPLE_COUNT, 16'd8);
    apply_regs();
    repeat (3) send_sample(12'hFFF);
    drain();
    stage_reg(REG_SAMPLE_COUNT, 16'd2);
    apply_regs();
    send_sample(12'd1000);
    drain();
  endtask

  // Count zero behaves as one; clamps at both curve ends, interpolation and
  // the presence threshold on either side.
  task automatic test_count_zero_and_curve();
    stage_reg(REG_SAMPLE_COUNT, 16'd0);
    apply_regs();
    send_sample(12'd2100);
    send_sample(12'd1650);
    send_sample(12'd1825);
    send_sample(12'd1249);
    send_sample(12'd1250);
    drain();
  endtask

  // Thresholds above full charge, and critical taking priority over low.
  // Writes to the spare indexes must change nothing.
  task automatic test_threshold_order();
    stage_reg(REG_LOW, 16'd1023);
    stage_reg(REG_CRITICAL, 16'd1023);
    for (int k = int'(REG_CRITICAL) + 1; k < (1 << CFG_IDX_W); k++)
      stage_reg(CFG_IDX_W'(k), 16'hFFFF);
    apply_regs();
    send_sample(12'd2100);
    drain();
    stage_reg(REG_CRITICAL, 16'd0);
    apply_regs();
    send_sample(12'd2100);
    drain();
  endtask

  // Upper data bits are dropped; the scaled value saturates at full scale.
  task automatic test_saturation();
    stage_reg(REG_DIVIDER, 16'hFFFF);
    stage_reg(REG_PRESENT_MIN, 16'hFFFF);
    apply_regs();
    send_sample(12'hFFF);
    drain();
  endtask

  // The receiver holds off for a long stretch while samples keep coming.
  task automatic test_output_backpressure();
    stage_reg(REG_SAMPLE_COUNT, 16'd1);
    stage_reg(REG_DIVIDER, 16'd512);
    stage_reg(REG_PRESENT_MIN, 16'd2500);
    stage_reg(REG_LOW, 16'd200);
    stage_reg(REG_CRITICAL, 16'd50);
    apply_regs();
    gaps_on = 1'b0;
    hold_request = 1'b1;
    repeat (14) send_sample(SAMPLE_W'($urandom_range(1600, 2150)));
    gaps_on = 1'b1;
    drain();
  endtask

  task automatic test_random_phases();
    int sent;
    int phase;
    int eff;
    int per;
    int c;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0: begin
          stage_reg(REG_SAMPLE_COUNT, 16'd64);
          stage_reg(REG_DIVIDER, 16'd4096);
          stage_reg(REG_PRESENT_MIN, 16'd0);
          stage_reg(REG_LOW, 16'd1000);
          stage_reg(REG_CRITICAL, 16'd0);
        end
        1: begin
          stage_reg(REG_SAMPLE_COUNT, 16'd127);
          stage_reg(REG_DIVIDER, 16'd256);
          stage_reg(REG_PRESENT_MIN, 16'd65535);
          stage_reg(REG_LOW, 16'd0);
          stage_reg(REG_CRITICAL, 16'd1000);
        end
        2: begin
          stage_reg(REG_SAMPLE_COUNT, 16'd1);
          stage_reg(REG_DIVIDER, 16'd512);
          stage_reg(REG_PRESENT_MIN, 16'd3300);
          stage_reg(REG_LOW, 16'd200);
          stage_reg(REG_CRITICAL, 16'd50);
        end
        default: begin
          case ($urandom_range(0, 3))
            0: c = $urandom_range(1, 4);
            1: c = $urandom_range(1, 64);
            2: c = $urandom_range(5, 16);
            default: begin
              case ($urandom_range(0, 2))
                0: c = 0;
                1: c = 64;
                default: c = 127;
              endcase
            end
          endcase
          stage_reg(REG_SAMPLE_COUNT, CFG_DATA_W'(c));
          if ($urandom_range(0, 3) == 0)
            stage_reg(REG_DIVIDER, $urandom_range(0, 1) ? 16'd256 : 16'd4096);
          else
            stage_reg(REG_DIVIDER, CFG_DATA_W'($urandom_range(256, 4096)));
          case ($urandom_range(0, 3))
            0: stage_reg(REG_PRESENT_MIN, 16'd2500);
            1: stage_reg(REG_PRESENT_MIN, CFG_DATA_W'($urandom_range(0, 65535)));
            2: stage_reg(REG_PRESENT_MIN, CFG_DATA_W'($urandom_range(3250, 4250)));
            default: stage_reg(REG_PRESENT_MIN, $urandom_range(0, 1) ? 16'd0 : 16'hFFFF);
          endcase
          if ($urandom_range(0, 1) == 0) begin
            c = $urandom_range(0, 500);
            stage_reg(REG_CRITICAL, CFG_DATA_W'(c));
            stage_reg(REG_LOW, CFG_DATA_W'(c + $urandom_range(0, 500)));
          end else begin
            stage_reg(REG_CRITICAL, CFG_DATA_W'($urandom_range(0, 1023)));
            stage_reg(REG_LOW, CFG_DATA_W'($urandom_range(0, 1023)));
          end
        end
      endcase
      apply_regs();
      eff = (set_count == 0) ? 1 : (set_count > MAX_SAMPLES_DEF) ? MAX_SAMPLES_DEF
                                                                   : int'(set_count);
      gaps_on = ($urandom_range(0, 3) != 0);
      per = eff * ((eff > 16) ? $urandom_range(2, 4) : $urandom_range(3, 15))
            + $urandom_range(0, eff - 1);
      repeat (per) send_sample(next_sample());
      sent += per;
      gaps_on = 1'b1;
      drain();
      phase++;
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_count_lowered();
    test_count_zero_and_curve();
    test_threshold_order();
    test_saturation();
    test_output_backpressure();
    test_random_phases();
    if (fail_count == 0 && estimate_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
